FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the running median filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on the house clock and reset names.
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: design/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg
// Widths, limits and the cell record shared by the running median filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned MedianW    = 17;
  localparam int unsigned HeldW      = 3;
  localparam int unsigned MaxWindow  = 64;
  localparam int unsigned DefWindow  = 5;
  localparam int unsigned AgeW       = $clog2(MaxWindow);
  localparam int unsigned InTdataW   = 16;
  localparam int unsigned OutTdataW  = 24;

  // One slot of the sorted chain: the sample and how many requests ago it came.
  typedef struct packed {
    logic               valid;
    logic [AgeW-1:0]    age;
    logic [SampleW-1:0] value;
  } cell_t;

endpackage

FILE: design/swmf_cell.sv
// ----------------------------------------------------------------------------
// swmf_cell
// One slot of the sorted chain. On each request it drops the oldest sample
// once the window is full, closes the gap and opens a slot for the new
// sample, looking only at its two neighbours.
// ----------------------------------------------------------------------------
module swmf_cell import swmf_pkg::*; #(
  parameter int unsigned Window = DefWindow
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_en_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               evict_i,
  input  logic [SampleW-1:0] oldest_i,
  input  cell_t              left_i,
  input  logic               left_lt_i,
  input  cell_t              right_i,
  output cell_t              cell_o,
  output cell_t              comp_o,
  output logic               comp_lt_o
);

  cell_t              cell_q, cell_d;
  logic               valid_q;
  logic [AgeW-1:0]    age_q;
  logic [SampleW-1:0] value_q;
  logic               evict_here;
  logic               above_evict;

  // Stored slot, assembled from its occupancy and payload registers.
  assign cell_q = {valid_q, age_q, value_q};

  // View of this slot once the oldest sample has been removed. Ties sort
  // younger first, so every slot above the evicted one holds a larger value.
  always_comb begin
    evict_here  = evict_i && cell_q.valid && (cell_q.age == AgeW'(Window - 1));
    above_evict = evict_i && cell_q.valid &&
                  ($signed(cell_q.value) > $signed(oldest_i));
    comp_o      = (evict_here || above_evict) ? right_i : cell_q;
    comp_lt_o   = comp_o.valid && ($signed(comp_o.value) < $signed(sample_i));
  end

  // Insert: keep smaller values, put the new sample at the boundary and move
  // everything else up by one slot. Every held sample grows one request older.
  always_comb begin
    cell_d = left_i;
    if (comp_lt_o) begin
      cell_d     = comp_o;
      cell_d.age = comp_o.age + 1'b1;
    end else if (left_lt_i) begin
      cell_d.valid = 1'b1;
      cell_d.age   = '0;
      cell_d.value = sample_i;
    end else begin
      cell_d.age = left_i.age + 1'b1;
    end
  end

  // Occupancy is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_en_i) begin
      valid_q <= cell_d.valid;
    end
  end

  // Sample and age are payload only.
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      age_q   <= cell_d.age;
      value_q <= cell_d.value;
    end
  end

  assign cell_o = cell_q;

endmodule

FILE: design/sliding_window_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_window_median_filter
// Running median over the last Window signed 16-bit samples, kept in a
// sorted chain of cells; the result is twice the median, exact for even
// counts.
//
//   Channel  Dir  Handshake                   Contents
//   s_axis   in   s_axis_tvalid/s_axis_tready sample
//   m_axis   out  m_axis_tvalid/m_axis_tready median_doubled, samples_held
//
// One sample is taken per cycle while the output side keeps up; each request
// first updates the chain, then the median pick and add fill the output register.
// The chain inserts and evicts in the same cycle, so back-to-back requests run
// at one per cycle while the output side keeps up. A stalled output holds one
// result and one more in the pick stage, after which s_axis_tready falls.
// Reset empties the window at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_median_filter import swmf_pkg::*; #(
  parameter int unsigned Window = DefWindow
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [15:0] sample
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata    // [16:0] median_doubled,
                                               // [19:17] samples_held, rest 0
);

  localparam int unsigned CntW = $clog2(Window + 1);

  logic               accept;
  logic               full;
  logic [CntW-1:0]    count_q, count_d;
  logic [SampleW-1:0] hist_q [Window];
  cell_t              cells      [Window];
  cell_t              comps      [Window];
  logic               comps_lt   [Window];
  cell_t              left_in    [Window];
  logic               left_lt_in [Window];
  cell_t              right_in   [Window];

  logic               pend_q, pend_d;
  logic               load_out;
  logic [CntW-1:0]    lo_idx, hi_idx;
  logic [SampleW-1:0] lo_part [Window];
  logic [SampleW-1:0] hi_part [Window];
  logic [SampleW-1:0] lo_val, hi_val;
  logic [MedianW-1:0] med_sum;

  logic               out_valid_q, out_valid_d;
  logic [MedianW-1:0] out_med_q;
  logic [HeldW-1:0]   out_held_q;

  // Request handshake: the pick stage must be free or able to move on.
  assign load_out      = pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_q || load_out;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(Window));

  // Fill count grows during warm-up and then stays at the window size.
  always_comb begin
    count_d = count_q;
    if (accept && !full) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Arrival-order shift line; its last tap is the sample to evict once full.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_q[0] <= s_axis_tdata[SampleW-1:0];
      for (int k = 1; k < Window; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  // Sorted chain of cells, smallest value in cell 0.
  for (genvar g = 0; g < Window; g++) begin : g_chain
    if (g == 0) begin : g_first
      assign left_in[g]    = '0;
      assign left_lt_in[g] = 1'b1;
    end else begin : g_inner
      assign left_in[g]    = comps[g-1];
      assign left_lt_in[g] = comps_lt[g-1];
    end
    if (g == Window - 1) begin : g_last
      assign right_in[g] = '0;
    end else begin : g_below
      assign right_in[g] = cells[g+1];
    end

    swmf_cell #(
      .Window (Window)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (accept),
      .sample_i   (s_axis_tdata[SampleW-1:0]),
      .evict_i    (full),
      .oldest_i   (hist_q[Window-1]),
      .left_i     (left_in[g]),
      .left_lt_i  (left_lt_in[g]),
      .right_i    (right_in[g]),
      .cell_o     (cells[g]),
      .comp_o     (comps[g]),
      .comp_lt_o  (comps_lt[g])
    );

    // Each cell offers its value when it sits at one of the middle places.
    assign lo_part[g] = (CntW'(g) == lo_idx) ? cells[g].value : '0;
    assign hi_part[g] = (CntW'(g) == hi_idx) ? cells[g].value : '0;
  end

  // Pick stage: the two middle places of the held count; for an odd count
  // they coincide, so the sum is always twice the median.
  assign lo_idx = (count_q - 1'b1) >> 1;
  assign hi_idx = count_q >> 1;

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int k = 0; k < Window; k++) begin
      lo_val = lo_val | lo_part[k];
      hi_val = hi_val | hi_part[k];
    end
    med_sum = {lo_val[SampleW-1], lo_val} + {hi_val[SampleW-1], hi_val};
  end

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (load_out) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_med_q  <= med_sum;
      out_held_q <= HeldW'(count_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - MedianW - HeldW){1'b0}}, out_held_q, out_med_q};

endmodule

FILE: design/swmf_checker.sv
// ----------------------------------------------------------------------------
// swmf_checker
// Port-level checks on the running median filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swmf_checker import swmf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  // A stalled result keeps its value until it is taken.
  `ASSERT_DEF(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // With an odd count the result is twice one sample, hence even.
  `ASSERT_DEF(a_odd_even, m_axis_tvalid && m_axis_tdata[17] |-> !m_axis_tdata[0], "odd count gave an odd doubled median")

  // Padding above the result fields stays clear.
  `ASSERT_DEF(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[OutTdataW-1:20] == '0, "padding bits set")

  // With no result waiting, the pick stage always drains, so requests are taken.
  `ASSERT_DEF(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (.*);
